FILE: rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL. Each expects signals named clock and reset in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define NPG_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checks that a condition in one cycle implies another in the next cycle.
`define NPG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/core/npg_pkg.sv
package npg_pkg;

   localparam int KEY_W = 16;
   localparam int POS_W = 4;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_STEP = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EMIT,
      ST_SORT_A,
      ST_SORT_B
   } state_type;

   typedef struct packed {
      logic             load_fire;
      logic [POS_W-1:0] load_position;
      logic [KEY_W-1:0] load_key;
      logic             rotate;
      logic             sort_en;
      logic             parity;
      logic             phase_b;
      logic [POS_W-1:0] region_start;
      logic [KEY_W-1:0] pivot_key;
   } cell_ctrl_type;

   // Ordering used by the sorting passes. In the first pass keys above the pivot key rank
   // before the others, so the smallest of them settles in the pivot slot.
   function automatic logic ranks_after(input logic [KEY_W-1:0] a,
                                        input logic [KEY_W-1:0] b,
                                        input logic [KEY_W-1:0] p,
                                        input logic             phase_b);
      logic [KEY_W:0] ra;
      logic [KEY_W:0] rb;
      ra = {(a <= p), a};
      rb = {(b <= p), b};
      if (phase_b) begin
         return a > b;
      end
      return ra > rb;
   endfunction

endpackage

FILE: rtl/core/npg_cell.sv
module npg_cell #(
   parameter int IDX     = 0,
   parameter bit IS_LAST = 1'b0
) (
   input  logic                         clock,
   input  npg_pkg::cell_ctrl_type       ctrl,
   input  logic [npg_pkg::KEY_W-1:0]    left_key,
   input  logic [npg_pkg::KEY_W-1:0]    right_key,
   input  logic                         swap_from_left,
   output logic [npg_pkg::KEY_W-1:0]    key_out,
   output logic                         swap_right
);

   localparam logic [npg_pkg::POS_W-1:0] IDX_P = npg_pkg::POS_W'(IDX);

   logic [npg_pkg::KEY_W-1:0] key_ff;
   logic [npg_pkg::KEY_W-1:0] key_in;

   // This cell is the left member of an active compare-exchange pair whose keys are out of order.
   assign swap_right = ctrl.sort_en && !IS_LAST && (IDX_P[0] == ctrl.parity) &&
                       (IDX_P >= ctrl.region_start) &&
                       npg_pkg::ranks_after(key_ff, right_key, ctrl.pivot_key, ctrl.phase_b);

   always_comb begin
      key_in = key_ff;
      if (ctrl.load_fire && (ctrl.load_position == IDX_P)) begin
         key_in = ctrl.load_key;
      end else if (ctrl.rotate || swap_right) begin
         key_in = right_key;
      end else if (swap_from_left) begin
         key_in = left_key;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign key_out = key_ff;

endmodule

FILE: rtl/core/npg_seq.sv
`include "assert_macros.svh"

module npg_seq #(
   parameter int NUM_KEYS = 10
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_op,
   input  logic [npg_pkg::POS_W-1:0]    req_position,
   input  logic [npg_pkg::KEY_W-1:0]    req_key,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [npg_pkg::KEY_W-1:0]    rsp_out_key,
   output logic [npg_pkg::POS_W-1:0]    rsp_out_position,
   output logic                         rsp_last,
   output logic                         rsp_finished,
   input  logic [npg_pkg::KEY_W-1:0]    keys [NUM_KEYS],
   output npg_pkg::cell_ctrl_type       ctrl
);

   localparam logic [npg_pkg::POS_W-1:0] LAST_POS = npg_pkg::POS_W'(NUM_KEYS - 1);

   npg_pkg::state_type          state_ff, state_in;
   logic [npg_pkg::POS_W-1:0]   cnt_ff, cnt_in;
   logic [npg_pkg::POS_W-1:0]   pivot_ff, pivot_in;
   logic [npg_pkg::KEY_W-1:0]   pivot_key_ff, pivot_key_in;
   logic                        finished_ff, finished_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic [npg_pkg::KEY_W-1:0]   out_key_ff;
   logic [npg_pkg::POS_W-1:0]   out_pos_ff;
   logic                        out_last_ff;
   logic                        out_finished_ff;
   logic                        req_fire;
   logic                        emit_fire;
   logic                        found;

   // Nothing is taken during reset or while a step is being worked on.
   assign req_stall = reset || (state_ff != npg_pkg::ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign emit_fire = (state_ff == npg_pkg::ST_EMIT) && (!rsp_valid_ff || !rsp_stall);

   // The pivot is the rightmost ascent; with none the arrangement is the last one.
   always_comb begin
      found    = 1'b0;
      pivot_in = '0;
      for (int i = 0; i < NUM_KEYS - 1; i++) begin
         if (keys[i] < keys[i+1]) begin
            found    = 1'b1;
            pivot_in = npg_pkg::POS_W'(i);
         end
      end
      pivot_key_in = keys[pivot_in];
      finished_in  = !found;
   end

   always_comb begin
      state_in             = state_ff;
      cnt_in               = cnt_ff;
      ctrl                 = '0;
      ctrl.load_position   = req_position;
      ctrl.load_key        = req_key;
      ctrl.pivot_key       = pivot_key_ff;
      ctrl.parity          = cnt_ff[0];
      ctrl.region_start    = pivot_ff;
      unique case (state_ff)
         npg_pkg::ST_IDLE: begin
            ctrl.load_fire = req_fire && (req_op == 1'(npg_pkg::OP_LOAD));
            if (req_fire && (req_op == 1'(npg_pkg::OP_STEP))) begin
               state_in = npg_pkg::ST_SCAN;
            end
         end
         npg_pkg::ST_SCAN: begin
            cnt_in   = '0;
            state_in = npg_pkg::ST_EMIT;
         end
         npg_pkg::ST_EMIT: begin
            // Each transfer rotates the chain by one slot, so the run ends where it began.
            ctrl.rotate = emit_fire;
            if (emit_fire) begin
               cnt_in = cnt_ff + 1'b1;
               if (cnt_ff == LAST_POS) begin
                  cnt_in   = '0;
                  state_in = finished_ff ? npg_pkg::ST_IDLE : npg_pkg::ST_SORT_A;
               end
            end
         end
         npg_pkg::ST_SORT_A: begin
            ctrl.sort_en = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == LAST_POS) begin
               cnt_in   = '0;
               state_in = npg_pkg::ST_SORT_B;
            end
         end
         npg_pkg::ST_SORT_B: begin
            ctrl.sort_en      = 1'b1;
            ctrl.phase_b      = 1'b1;
            ctrl.region_start = pivot_ff + 1'b1;
            cnt_in            = cnt_ff + 1'b1;
            if (cnt_ff == LAST_POS) begin
               cnt_in   = '0;
               state_in = npg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = npg_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = emit_fire || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= npg_pkg::ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == npg_pkg::ST_SCAN) begin
         pivot_ff     <= pivot_in;
         pivot_key_ff <= pivot_key_in;
         finished_ff  <= finished_in;
      end
      if (emit_fire) begin
         out_key_ff      <= keys[0];
         out_pos_ff      <= cnt_ff;
         out_last_ff     <= (cnt_ff == LAST_POS);
         out_finished_ff <= finished_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_key      = out_key_ff;
   assign rsp_out_position = out_pos_ff;
   assign rsp_last         = out_last_ff;
   assign rsp_finished     = out_finished_ff;

   `NPG_ASSERT_NEXT(a_scan_starts_run, state_ff == npg_pkg::ST_SCAN,
      (state_ff == npg_pkg::ST_EMIT) && (cnt_ff == '0), "scan must start a run at slot zero")
   `NPG_ASSERT_NEXT(a_run_ends, emit_fire && (cnt_ff == LAST_POS),
      state_ff != npg_pkg::ST_EMIT, "run must end after the last slot")
   `NPG_ASSERT(a_no_sort_when_done,
      ((state_ff == npg_pkg::ST_SORT_A) || (state_ff == npg_pkg::ST_SORT_B)) |-> !finished_ff,
      "final arrangement must not be reordered")

endmodule

FILE: rtl/core/next_permutation_generator.sv
// Loads are taken one per cycle while no step is being worked on. A step is taken and is
// scanned for its pivot in the next cycle; its NUM_KEYS results are then offered in slot
// order, one per cycle while the output does not stall. Odd-even passes along the cell
// chain then reorder the keys from the pivot on, and the next item is taken once they end,
// or once the run ends after a final arrangement.
// Reset clears the sequencer and the output valid; keys are undefined until loaded.
module next_permutation_generator #(
   parameter int NUM_KEYS = 10
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_op,
   input  logic [npg_pkg::POS_W-1:0]    req_position,
   input  logic [npg_pkg::KEY_W-1:0]    req_key,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [npg_pkg::KEY_W-1:0]    rsp_out_key,
   output logic [npg_pkg::POS_W-1:0]    rsp_out_position,
   output logic                         rsp_last,
   output logic                         rsp_finished
);

   npg_pkg::cell_ctrl_type     ctrl;
   logic [npg_pkg::KEY_W-1:0]  keys [NUM_KEYS];
   logic [NUM_KEYS-1:0]        swap_right;

   npg_seq #(
      .NUM_KEYS(NUM_KEYS)
   ) u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_op          (req_op),
      .req_position    (req_position),
      .req_key         (req_key),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_key     (rsp_out_key),
      .rsp_out_position(rsp_out_position),
      .rsp_last        (rsp_last),
      .rsp_finished    (rsp_finished),
      .keys            (keys),
      .ctrl            (ctrl)
   );

   for (genvar g = 0; g < NUM_KEYS; g++) begin : g_cell
      npg_cell #(
         .IDX    (g),
         .IS_LAST(g == NUM_KEYS - 1)
      ) u_cell (
         .clock         (clock),
         .ctrl          (ctrl),
         .left_key      (keys[(g + NUM_KEYS - 1) % NUM_KEYS]),
         .right_key     (keys[(g + 1) % NUM_KEYS]),
         .swap_from_left((g == 0) ? 1'b0 : swap_right[(g + NUM_KEYS - 1) % NUM_KEYS]),
         .key_out       (keys[g]),
         .swap_right    (swap_right[g])
      );
   end

endmodule

FILE: tb/sv/tb_next_permutation_generator.sv
module tb_next_permutation_generator;

   localparam int NUM_KEYS      = 10;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int SETTLE_CYCLES = 4 * NUM_KEYS + 10;
   localparam int STIM_ITEMS    = 280;

   typedef struct {
      npg_pkg::op_type                op;
      logic [npg_pkg::POS_W-1:0]      position;
      logic [npg_pkg::KEY_W-1:0]      key;
      bit                             hold;
   } command_type;

   typedef struct {
      logic [npg_pkg::KEY_W-1:0]      out_key;
      logic [npg_pkg::POS_W-1:0]      out_position;
      logic                           last;
      logic                           finished;
   } slot_result_type;

   typedef enum {
      FILL_RANDOM,
      FILL_FEW_VALUES,
      FILL_EXTREMES,
      FILL_NEAR_DESCENDING,
      FILL_ASCENDING,
      FILL_PARTIAL
   } fill_kind_type;

   logic                      clock;
   logic                      reset        = 1'b1;
   logic                      req_valid    = 1'b0;
   logic                      req_stall;
   logic                      req_op       = npg_pkg::OP_LOAD;
   logic [npg_pkg::POS_W-1:0] req_position = '0;
   logic [npg_pkg::KEY_W-1:0] req_key      = '0;
   logic                      rsp_valid;
   logic                      rsp_stall    = 1'b0;
   logic [npg_pkg::KEY_W-1:0] rsp_out_key;
   logic [npg_pkg::POS_W-1:0] rsp_out_position;
   logic                      rsp_last;
   logic                      rsp_finished;

   command_type               pending_cmds[$];
   slot_result_type           awaited_slots[$];
   logic [npg_pkg::KEY_W-1:0] shadow_keys[NUM_KEYS];
   bit                        failed         = 1'b0;
   int                        stim_count     = 0;
   int                        accepted_count = 0;
   bit                        req_took       = 1'b0;
   bit                        rsp_took       = 1'b0;
   int                        send_gap       = 0;
   int                        rsp_wait       = 0;
   bit                        send_calm      = 1'b0;
   bit                        recv_calm      = 1'b0;

   next_permutation_generator #(.NUM_KEYS(NUM_KEYS)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_op           (req_op),
      .req_position     (req_position),
      .req_key          (req_key),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_key      (rsp_out_key),
      .rsp_out_position (rsp_out_position),
      .rsp_last         (rsp_last),
      .rsp_finished     (rsp_finished)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic bit has_ascent();
      for (int k = 0; k + 1 < NUM_KEYS; k++) begin
         if (shadow_keys[k] < shadow_keys[k + 1]) begin
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // Lexicographic successor in place; a descending arrangement stays as it is.
   function automatic void advance_arrangement();
      int                        pivot;
      int                        swap_at;
      int                        lo;
      int                        hi;
      logic [npg_pkg::KEY_W-1:0] t;
      pivot = -1;
      for (int k = 0; k + 1 < NUM_KEYS; k++) begin
         if (shadow_keys[k] < shadow_keys[k + 1]) begin
            pivot = k;
         end
      end
      if (pivot < 0) begin
         return;
      end
      // The slot after the pivot holds a larger key, so this search always stops.
      swap_at = NUM_KEYS - 1;
      while (shadow_keys[swap_at] <= shadow_keys[pivot]) begin
         swap_at--;
      end
      t = shadow_keys[pivot];
      shadow_keys[pivot] = shadow_keys[swap_at];
      shadow_keys[swap_at] = t;
      lo = pivot + 1;
      hi = NUM_KEYS - 1;
      while (lo < hi) begin
         t = shadow_keys[lo];
         shadow_keys[lo] = shadow_keys[hi];
         shadow_keys[hi] = t;
         lo++;
         hi--;
      end
   endfunction

   function automatic void predict_command(command_type c);
      slot_result_type r;
      bit              done;
      if (c.op == npg_pkg::OP_LOAD) begin
         if (c.position < NUM_KEYS) begin
            shadow_keys[c.position] = c.key;
         end
      end else begin
         done = !has_ascent();
         for (int k = 0; k < NUM_KEYS; k++) begin
            r.out_key = shadow_keys[k];
            r.out_position = npg_pkg::POS_W'(k);
            r.last = (k == NUM_KEYS - 1);
            r.finished = done;
            awaited_slots.push_back(r);
         end
         advance_arrangement();
      end
   endfunction

   task automatic push_cmd(npg_pkg::op_type op, int position, int key, bit hold);
      command_type c;
      c.op = op;
      c.position = npg_pkg::POS_W'(position);
      c.key = npg_pkg::KEY_W'(key);
      c.hold = hold;
      pending_cmds.push_back(c);
      stim_count++;
   endtask

   // Sender: a new item goes out once the previous transfer is done and its gap has run out.
   always @(negedge clock) begin : driver
      command_type c;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_cmds.size() > 0 &&
                      !(pending_cmds[0].hold && awaited_slots.size() > 0)) begin
            c = pending_cmds.pop_front();
            req_op <= c.op;
            req_position <= c.position;
            req_key <= c.key;
            req_valid <= 1'b1;
            if ($urandom_range(0, 29) == 0) begin
               send_calm <= !send_calm;
            end
            send_gap <= send_calm ? 0 : $urandom_range(0, 19);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: after each transfer it draws how long to hold off the next one.
   always @(negedge clock) begin : receiver
      int w;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_wait <= 0;
      end else begin
         w = rsp_took ? (recv_calm ? 0 : $urandom_range(0, 19)) : rsp_wait;
         if (rsp_took && $urandom_range(0, 29) == 0) begin
            recv_calm <= !recv_calm;
         end
         if (w > 0) begin
            rsp_stall <= 1'b1;
            rsp_wait <= w - 1;
         end else begin
            rsp_stall <= 1'b0;
            rsp_wait <= 0;
         end
      end
   end

   always @(posedge clock) begin : monitor
      slot_result_type want;
      command_type     c;
      if (reset) begin
         req_took <= 1'b0;
         rsp_took <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_slots.size() == 0) begin
               $error("result with none awaited: out_position %0d, out_key %h",
                      rsp_out_position, rsp_out_key);
               failed = 1'b1;
            end else begin
               want = awaited_slots.pop_front();
               if (rsp_out_key !== want.out_key) begin
                  $error("out_key: expected %h, got %h", want.out_key, rsp_out_key);
                  failed = 1'b1;
               end
               if (rsp_out_position !== want.out_position) begin
                  $error("out_position: expected %0d, got %0d",
                         want.out_position, rsp_out_position);
                  failed = 1'b1;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %b, got %b", want.last, rsp_last);
                  failed = 1'b1;
               end
               if (rsp_finished !== want.finished) begin
                  $error("finished: expected %b, got %b", want.finished, rsp_finished);
                  failed = 1'b1;
               end
            end
         end
         if (req_valid && !req_stall) begin
            c.op = npg_pkg::op_type'(req_op);
            c.position = req_position;
            c.key = req_key;
            c.hold = 1'b0;
            predict_command(c);
            accepted_count++;
         end
         req_took <= req_valid && !req_stall;
         rsp_took <= rsp_valid && !rsp_stall;
      end
   end

   initial begin : watchdog
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin : stimulus
      logic [npg_pkg::KEY_W-1:0] set_keys[NUM_KEYS];
      logic [npg_pkg::KEY_W-1:0] t;
      fill_kind_type             kind;
      int                        offset;
      int                        reversed;
      int                        slot;
      int                        steps;
      int                        n;

      // Descending order with a repeated key, apart from the last two slots.
      set_keys = '{16'hFFFF, 16'h8000, 16'h8000, 16'h7FFF, 16'h1234,
                   16'h00FF, 16'h0010, 16'h0002, 16'h0000, 16'h0001};
      for (int k = 0; k < NUM_KEYS; k++) begin
         push_cmd(npg_pkg::OP_LOAD, k, set_keys[k], 1'b0);
      end
      // Slots beyond the arrangement must be ignored.
      push_cmd(npg_pkg::OP_LOAD, 10, 16'h5555, 1'b0);
      push_cmd(npg_pkg::OP_LOAD, 15, 16'hAAAA, 1'b0);
      // One real successor, then the descending arrangement twice.
      push_cmd(npg_pkg::OP_STEP, 15, 16'hFFFF, 1'b0);
      push_cmd(npg_pkg::OP_STEP, 0, 16'h0000, 1'b0);
      push_cmd(npg_pkg::OP_STEP, 5, 16'h1234, 1'b1);
      push_cmd(npg_pkg::OP_LOAD, 0, 16'h0000, 1'b1);
      push_cmd(npg_pkg::OP_STEP, 10, 16'h5555, 1'b0);
      push_cmd(npg_pkg::OP_STEP, 3, 16'hAAAA, 1'b0);

      while (stim_count < STIM_ITEMS) begin
         kind = fill_kind_type'($urandom_range(0, 5));
         if (kind == FILL_PARTIAL) begin
            n = $urandom_range(1, 3);
            for (int k = 0; k < n; k++) begin
               push_cmd(npg_pkg::OP_LOAD, $urandom_range(0, NUM_KEYS - 1), $urandom, 1'b0);
            end
         end else begin
            case (kind)
               FILL_FEW_VALUES: begin
                  foreach (set_keys[k]) set_keys[k] = npg_pkg::KEY_W'($urandom_range(0, 2));
               end
               FILL_EXTREMES: begin
                  foreach (set_keys[k]) set_keys[k] = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
               end
               FILL_NEAR_DESCENDING: begin
                  // Falls by at most three per slot, so it cannot wrap below zero.
                  set_keys[0] = npg_pkg::KEY_W'($urandom_range(30, 65535));
                  for (int k = 1; k < NUM_KEYS; k++) begin
                     set_keys[k] = npg_pkg::KEY_W'(set_keys[k - 1] - $urandom_range(0, 3));
                  end
                  slot = $urandom_range(NUM_KEYS - 4, NUM_KEYS - 2);
                  t = set_keys[slot];
                  set_keys[slot] = set_keys[slot + 1];
                  set_keys[slot + 1] = t;
               end
               FILL_ASCENDING: begin
                  set_keys[0] = npg_pkg::KEY_W'($urandom_range(0, 65535 - NUM_KEYS));
                  for (int k = 1; k < NUM_KEYS; k++) begin
                     set_keys[k] = npg_pkg::KEY_W'(set_keys[k - 1] + 1);
                  end
               end
               default: begin
                  foreach (set_keys[k]) set_keys[k] = npg_pkg::KEY_W'($urandom);
               end
            endcase
            offset = $urandom_range(0, NUM_KEYS - 1);
            reversed = $urandom_range(0, 1);
            for (int k = 0; k < NUM_KEYS; k++) begin
               slot = reversed ? (offset + NUM_KEYS - k) % NUM_KEYS : (offset + k) % NUM_KEYS;
               push_cmd(npg_pkg::OP_LOAD, slot, set_keys[slot], 1'b0);
            end
         end
         if ($urandom_range(0, 3) == 0) begin
            push_cmd(npg_pkg::OP_LOAD, $urandom_range(NUM_KEYS, 15), $urandom, 1'b0);
         end
         steps = $urandom_range(1, 6);
         for (int k = 0; k < steps; k++) begin
            push_cmd(npg_pkg::OP_STEP, $urandom_range(0, 15), $urandom,
                     k == 0 && $urandom_range(0, 7) == 0);
         end
      end

      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // Every item must have been taken and every result that it caused seen.
      while (accepted_count < stim_count || awaited_slots.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (!failed) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
